>>> sv/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// shared types for the signed shift-subtract divider pipeline
// ----------------------------------------------------------------------------
package ssd_pkg;

  // control bits that travel beside each item through the pipeline
  typedef struct packed {
    logic valid;  // stage holds an item
    logic neg;    // operand signs differ, negate the quotient at the end
    logic sat;    // zero divisor or overflow, force the largest positive value
  } ctl_t;

endpackage

>>> sv/ssd_stage.sv
// ----------------------------------------------------------------------------
// ssd_stage
// one restoring division step: settles one quotient bit, msb first
// ----------------------------------------------------------------------------
module ssd_stage #(
  parameter int WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  ssd_pkg::ctl_t       ctl_i,
  input  logic [WIDTH-1:0]    num_i,
  input  logic [WIDTH-1:0]    den_i,
  input  logic [WIDTH-1:0]    rem_i,
  input  logic [WIDTH-1:0]    quo_i,
  output ssd_pkg::ctl_t       ctl_o,
  output logic [WIDTH-1:0]    num_o,
  output logic [WIDTH-1:0]    den_o,
  output logic [WIDTH-1:0]    rem_o,
  output logic [WIDTH-1:0]    quo_o
);

  ssd_pkg::ctl_t    ctl_r;
  logic [WIDTH-1:0] num_r;
  logic [WIDTH-1:0] den_r;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] quo_r;

  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   diff;
  logic             q_bit;
  logic [WIDTH-1:0] rem_nxt;

  // bring down the next dividend bit and try the subtraction
  always_comb begin
    rem_sh  = {rem_i, num_i[WIDTH-1]};
    diff    = rem_sh - {1'b0, den_i};
    q_bit   = !diff[WIDTH];
    rem_nxt = q_bit ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= {num_i[WIDTH-2:0], 1'b0};
      den_r <= den_i;
      rem_r <= rem_nxt;
      quo_r <= {quo_i[WIDTH-2:0], q_bit};
    end
  end

  assign ctl_o = ctl_r;
  assign num_o = num_r;
  assign den_o = den_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;

endmodule

>>> sv/signed_shift_subtract_divider_top.sv
// ----------------------------------------------------------------------------
// signed_shift_subtract_divider_top
// pipelined signed integer divider, quotient truncated toward zero
// ----------------------------------------------------------------------------
// usage:
//   input channel in_*: one transfer carries a dividend and a divisor, both
//   WIDTH-bit two's complement. result channel out_*: one transfer carries
//   the WIDTH-bit signed quotient for each input transfer, in order.
//   a zero divisor, and the most negative dividend over minus one, give the
//   largest positive value 2^(WIDTH-1)-1.
// path: one operand stage, WIDTH restoring steps of one quotient bit each,
//   then one sign stage that registers the result.
// throughput: one item per cycle unless the output stalls; every step has
//   its own register stage with one WIDTH+1 bit subtract, so items follow
//   each other back to back.
// reset: synchronous, active low; clears all valid bits, the pipeline comes
//   up empty and out_tvalid low.
// stall: while out_tvalid is high and out_tready low the whole pipeline holds
//   and in_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module signed_shift_subtract_divider_top #(
  parameter int WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [((2*WIDTH+7)/8)*8-1:0]    in_tdata,   // dividend, divisor
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [((WIDTH+7)/8)*8-1:0]      out_tdata   // quotient
);

  localparam int OUT_W = ((WIDTH + 7) / 8) * 8;
  localparam logic [WIDTH-1:0] INT_MAX = {1'b0, {(WIDTH-1){1'b1}}};
  localparam logic [WIDTH-1:0] INT_MIN = {1'b1, {(WIDTH-1){1'b0}}};

  // output slot valid, set in the sign stage below
  logic out_tvalid_r;

  // global advance: the pipeline moves when the output slot is free or taken
  logic adv;
  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  // ---- operand stage: magnitudes, sign and special cases ----
  logic [WIDTH-1:0] dvd;
  logic [WIDTH-1:0] dvs;
  logic [WIDTH-1:0] dvd_mag;
  logic [WIDTH-1:0] dvs_mag;
  ssd_pkg::ctl_t    ctl_nxt;

  always_comb begin
    dvd           = in_tdata[WIDTH-1:0];
    dvs           = in_tdata[2*WIDTH-1:WIDTH];
    dvd_mag       = dvd[WIDTH-1] ? (~dvd + 1'b1) : dvd;
    dvs_mag       = dvs[WIDTH-1] ? (~dvs + 1'b1) : dvs;
    ctl_nxt.valid = in_tvalid;
    ctl_nxt.neg   = dvd[WIDTH-1] ^ dvs[WIDTH-1];
    // zero divisor, or most negative over minus one
    ctl_nxt.sat   = (dvs == '0) || ((dvd == INT_MIN) && (dvs == '1));
  end

  // stage chains: index 0 is the operand register, index WIDTH the last step
  ssd_pkg::ctl_t    ctl_s [WIDTH+1];
  logic [WIDTH-1:0] num_s [WIDTH+1];
  logic [WIDTH-1:0] den_s [WIDTH+1];
  logic [WIDTH-1:0] rem_s [WIDTH+1];
  logic [WIDTH-1:0] quo_s [WIDTH+1];

  ssd_pkg::ctl_t    ctl0_r;
  logic [WIDTH-1:0] num0_r;
  logic [WIDTH-1:0] den0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else if (adv) begin
      ctl0_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num0_r <= dvd_mag;
      den0_r <= dvs_mag;
    end
  end

  assign ctl_s[0] = ctl0_r;
  assign num_s[0] = num0_r;
  assign den_s[0] = den0_r;
  assign rem_s[0] = '0;
  assign quo_s[0] = '0;

  // ---- restoring steps, one quotient bit per stage ----
  for (genvar k = 0; k < WIDTH; k++) begin : g_step
    ssd_stage #(
      .WIDTH (WIDTH)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .ctl_i (ctl_s[k]),
      .num_i (num_s[k]),
      .den_i (den_s[k]),
      .rem_i (rem_s[k]),
      .quo_i (quo_s[k]),
      .ctl_o (ctl_s[k+1]),
      .num_o (num_s[k+1]),
      .den_o (den_s[k+1]),
      .rem_o (rem_s[k+1]),
      .quo_o (quo_s[k+1])
    );
  end

  // ---- sign stage and output register ----
  logic [WIDTH-1:0] res_r;
  logic [WIDTH-1:0] res_nxt;
  ssd_pkg::ctl_t    ctl_last;
  logic [WIDTH-1:0] quo_last;

  assign ctl_last = ctl_s[WIDTH];
  assign quo_last = quo_s[WIDTH];

  always_comb begin
    priority if (ctl_last.sat) begin
      res_nxt = INT_MAX;
    end else if (ctl_last.neg) begin
      res_nxt = ~quo_last + 1'b1;
    end else begin
      res_nxt = quo_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= ctl_last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  // remaining step outputs past the last stage carry no information
  logic unused_tail;
  assign unused_tail = ^{num_s[WIDTH], den_s[WIDTH], rem_s[WIDTH]};

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'({unused_tail & 1'b0, res_r});

endmodule

>>> sv/ssd_checker.sv
// ----------------------------------------------------------------------------
// ssd_checker
// port-level checks for the signed shift-subtract divider
// ----------------------------------------------------------------------------
module ssd_checker #(
  parameter int WIDTH = 32
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [((2*WIDTH+7)/8)*8-1:0]    in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [((WIDTH+7)/8)*8-1:0]      out_tdata
);

  // pipeline comes up empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds its value
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // input side is ready exactly when the output slot frees up
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow the output side");

  // handshakes are known, and so is the payload of any valid transfer
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_tvalid, in_tready, out_tvalid}) &&
    (!in_tvalid || !$isunknown(in_tdata)) &&
    (!out_tvalid || !$isunknown(out_tdata)))
    else $error("unknown value on a handshake or valid payload");

endmodule

bind signed_shift_subtract_divider_top ssd_checker #(.WIDTH(WIDTH)) u_ssd_checker (.*);
